/* sv/reliable_udp_ack_window_macros.svh */
`ifndef RELIABLE_UDP_ACK_WINDOW_MACROS_SVH
`define RELIABLE_UDP_ACK_WINDOW_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define RUA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is held
`define RUA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rua_pkg.sv */
`default_nettype none

package rua_pkg;

    localparam int SEQ_W   = 16;
    localparam int WIN_W   = 32;
    localparam int CMD_W   = 2;
    localparam int LIMIT_W = 16;
    localparam int IDLE_W  = 16;

    localparam logic [CMD_W-1:0] CMD_PKT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 16'd100;

    typedef logic [SEQ_W-1:0] t_seq;
    typedef logic [WIN_W-1:0] t_win;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_SYNC = 3'd1,
        OP_PKT  = 3'd2,
        OP_SEND = 3'd3,
        OP_TICK = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        KIND_IGNORED    = 4'd0,
        KIND_DELIVER    = 4'd1,
        KIND_SYNC_REPLY = 4'd2,
        KIND_SENT       = 4'd3,
        KIND_HELD       = 4'd4,
        KIND_NOT_TX     = 4'd5,
        KIND_RESEND     = 4'd6,
        KIND_DISCONNECT = 4'd7,
        KIND_IDLE       = 4'd8
    } t_kind;

    typedef struct packed {
        t_op  op;
        t_seq pkt_seq;
        t_seq pkt_ack;
        t_win pkt_ack_mask;
    } t_item;

    typedef struct packed {
        t_kind kind;
        t_seq  out_seq;
        t_seq  out_ack;
        t_win  out_ack_mask;
        t_win  newly_acked;
        t_seq  acked_base;
    } t_result;

endpackage

`default_nettype wire

/* sv/reliable_udp_ack_window.sv */
// Channel   Direction  Handshake            Words
// input     in         push / full          cmd, is_sync, pkt_seq, pkt_ack, pkt_ack_mask
// result    out        empty / pop          kind, out_seq, out_ack, out_ack_mask,
//                                           newly_acked, acked_base
// config    in         i_cfg_we             idle_limit_ticks
//
// One word per cycle sustained while results are popped; a word passes through the
// input queue, then the window update into the result queue.
// The window update is a combinational step: mask shifts and one priority encode.
// Two-entry queues on each side let input and result sides stall independently.
// Synchronous active-low reset; no clearing pass, ready as soon as reset is released.
`default_nettype none

module reliable_udp_ack_window
    import rua_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic               i_is_sync,
    input  wire logic [SEQ_W-1:0]   i_pkt_seq,
    input  wire logic [SEQ_W-1:0]   i_pkt_ack,
    input  wire logic [WIN_W-1:0]   i_pkt_ack_mask,
    output logic                    empty,
    input  wire logic               pop,
    output logic [3:0]              o_kind,
    output logic [SEQ_W-1:0]        o_out_seq,
    output logic [SEQ_W-1:0]        o_out_ack,
    output logic [WIN_W-1:0]        o_out_ack_mask,
    output logic [WIN_W-1:0]        o_newly_acked,
    output logic [SEQ_W-1:0]        o_acked_base,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata
);

`include "reliable_udp_ack_window_macros.svh"

    logic    w_item_valid;
    t_item   w_item;
    logic    w_take;
    t_result w_result;

    rua_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_is_sync      (i_is_sync),
        .i_pkt_seq      (i_pkt_seq),
        .i_pkt_ack      (i_pkt_ack),
        .i_pkt_ack_mask (i_pkt_ack_mask),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item),
        .i_take         (w_take)
    );

    rua_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .pop          (pop),
        .empty        (empty),
        .o_result     (w_result)
    );

    assign o_kind         = w_result.kind;
    assign o_out_seq      = w_result.out_seq;
    assign o_out_ack      = w_result.out_ack;
    assign o_out_ack_mask = w_result.out_ack_mask;
    assign o_newly_acked  = w_result.newly_acked;
    assign o_acked_base   = w_result.acked_base;

    `RUA_ASSERT_NOW(a_take_needs_item, i_clk, i_rst_n, w_take, w_item_valid,
        "take from empty input queue")
    `RUA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty,
        "result lost while not popped")
    `RUA_ASSERT_NOW(a_sent_seq_nonzero, i_clk, i_rst_n,
        !empty && (o_kind == KIND_SENT), o_out_seq != '0, "send assigned sequence zero")
    `RUA_ASSERT_NOW(a_disc_clean, i_clk, i_rst_n, !empty && (o_kind == KIND_DISCONNECT),
        (o_out_seq == '0) && (o_out_ack_mask == '0), "disconnect carries header data")

endmodule

`default_nettype wire

/* sv/rua_front.sv */
`default_nettype none

module rua_front
    import rua_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic               i_is_sync,
    input  wire logic [SEQ_W-1:0]   i_pkt_seq,
    input  wire logic [SEQ_W-1:0]   i_pkt_ack,
    input  wire logic [WIN_W-1:0]   i_pkt_ack_mask,
    output logic                    o_item_valid,
    output t_item                   o_item,
    input  wire logic               i_take
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    t_item      w_item;

    // classify the incoming word
    always_comb begin
        w_item.pkt_seq      = i_pkt_seq;
        w_item.pkt_ack      = i_pkt_ack;
        w_item.pkt_ack_mask = i_pkt_ack_mask;
        case (i_cmd)
            CMD_PKT:  w_item.op = i_is_sync ? OP_SYNC : OP_PKT;
            CMD_SEND: w_item.op = OP_SEND;
            CMD_TICK: w_item.op = OP_TICK;
            default:  w_item.op = OP_NOP;
        endcase
    end

    assign full         = (r_cnt == 2'd2);
    assign w_push       = push && !full;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_take) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

/* sv/rua_exec.sv */
`default_nettype none

module rua_exec
    import rua_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic               i_item_valid,
    input  wire t_item              i_item,
    output logic                    o_take,
    input  wire logic               pop,
    output logic                    empty,
    output t_result                 o_result
);

    localparam int UD_W = $clog2(WIN_W);
    localparam int RL_W = $clog2(WIN_W) + 1;
    localparam t_seq SEQ_ONES = '1;
    localparam t_seq SEQ_HALF = {1'b1, {(SEQ_W-1){1'b0}}};
    localparam t_win WIN_ONES = '1;
    localparam t_win WIN_ONE  = t_win'(1);
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    typedef enum logic [1:0] {
        LINK_DOWN = 2'd0,
        LINK_SYNC = 2'd1,
        LINK_UP   = 2'd2
    } t_link;

    typedef logic signed [SEQ_W:0] t_dist;

    // wrapped distance a - b; exactly half the space counts as ahead when a > b
    function automatic t_dist seq_dist(input t_seq a, input t_seq b);
        t_seq d;
        logic neg;
        d   = a - b;
        neg = d[SEQ_W-1] && !((d == SEQ_HALF) && (a > b));
        seq_dist = {neg, d};
    endfunction

    // zero is skipped in both directions
    function automatic t_seq seq_next(input t_seq s);
        seq_next = (s == SEQ_ONES) ? t_seq'(1) : s + t_seq'(1);
    endfunction

    function automatic t_seq seq_back(input t_seq s, input logic [UD_W-1:0] bias);
        logic [SEQ_W:0] wide;
        if (s > t_seq'(bias)) begin
            wide = {1'b0, s} - (SEQ_W+1)'(bias);
        end else begin
            wide = {1'b0, s} + {1'b0, SEQ_ONES} - (SEQ_W+1)'(bias);
        end
        seq_back = wide[SEQ_W-1:0];
    endfunction

    logic [LIMIT_W-1:0] r_limit;
    t_link              r_link;
    t_seq               r_local;
    t_win               r_ra;
    t_seq               r_latest;
    t_win               r_rmask;
    logic [RL_W-1:0]    r_rl;
    logic [IDLE_W-1:0]  r_idle;

    t_link              n_link;
    t_seq               n_local;
    t_win               n_ra;
    t_seq               n_latest;
    t_win               n_rmask;
    logic [RL_W-1:0]    n_rl;
    logic [IDLE_W-1:0]  n_idle;
    t_result            w_res;

    t_dist              w_sh;
    t_dist              w_neg;
    t_dist              w_ackd;
    logic [UD_W-1:0]    w_ud;
    t_win               w_newly;
    t_win               w_elig;
    logic [UD_W-1:0]    w_oldest;
    logic [IDLE_W-1:0]  w_idle_inc;
    logic               w_keep;
    logic               w_hdr;

    t_result            r_q [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    logic               w_pop;

    assign o_take = i_item_valid && (r_cnt != 2'd2);

    // window arithmetic shared by the packet and tick paths
    always_comb begin
        w_sh   = seq_dist(i_item.pkt_seq, r_latest);
        w_neg  = -w_sh;
        w_ackd = seq_dist(r_local, i_item.pkt_ack);
        w_ud   = w_ackd[UD_W-1:0];
        w_newly = (~r_ra >> w_ud) & i_item.pkt_ack_mask;
        w_idle_inc = (r_idle != IDLE_MAX) ? r_idle + 1'b1 : r_idle;
        w_elig = ~r_ra & ~(WIN_ONES >> r_rl);
        w_oldest = '0;
        for (int k = 0; k < WIN_W; k++) begin
            if (w_elig[k]) begin
                w_oldest = UD_W'(k);
            end
        end
    end

    always_comb begin
        n_link   = r_link;
        n_local  = r_local;
        n_ra     = r_ra;
        n_latest = r_latest;
        n_rmask  = r_rmask;
        n_rl     = r_rl;
        n_idle   = r_idle;
        w_res    = '0;
        w_res.kind = KIND_IGNORED;
        w_keep   = 1'b1;
        w_hdr    = 1'b0;
        case (i_item.op)
            OP_SYNC: begin
                n_idle = '0;
                if (r_link == LINK_DOWN) begin
                    n_link     = LINK_SYNC;
                    n_latest   = i_item.pkt_seq;
                    n_rmask    = WIN_ONE;
                    n_local    = seq_next(r_local);
                    n_ra       = WIN_ONES << 1;
                    n_rl       = RL_W'(WIN_W - 1);
                    w_res.kind = KIND_SYNC_REPLY;
                    w_res.out_seq = n_local;
                    w_hdr      = 1'b1;
                end
            end
            OP_PKT: begin
                n_idle = '0;
                if (r_link != LINK_DOWN) begin
                    n_link = LINK_UP;
                    if (w_sh == '0) begin
                        w_keep = 1'b0;
                    end else if (w_sh[SEQ_W]) begin
                        // older packet: mark it unless outside the window or seen
                        if (w_neg >= t_dist'(WIN_W)) begin
                            w_keep = 1'b0;
                        end else if (r_rmask[w_neg[UD_W-1:0]]) begin
                            w_keep = 1'b0;
                        end else begin
                            n_rmask = r_rmask | (WIN_ONE << w_neg[UD_W-1:0]);
                        end
                    end else begin
                        n_latest = i_item.pkt_seq;
                        if (w_sh >= t_dist'(WIN_W)) begin
                            n_rmask = WIN_ONE;
                        end else begin
                            n_rmask = (r_rmask << w_sh[UD_W-1:0]) | WIN_ONE;
                        end
                    end
                    if (w_keep) begin
                        if (!w_ackd[SEQ_W] && (w_ackd < t_dist'(WIN_W))) begin
                            w_res.newly_acked = w_newly;
                            n_ra = r_ra | (w_newly << w_ud);
                        end
                        w_res.kind       = KIND_DELIVER;
                        w_res.acked_base = i_item.pkt_ack;
                        w_hdr            = 1'b1;
                    end
                end
            end
            OP_SEND: begin
                if (!r_ra[WIN_W-1]) begin
                    w_res.kind = KIND_HELD;
                end else begin
                    n_local = seq_next(r_local);
                    n_ra    = r_ra << 1;
                    if (r_link == LINK_UP) begin
                        w_res.kind = KIND_SENT;
                        if (r_rl != '0) begin
                            n_rl = r_rl - 1'b1;
                        end
                    end else begin
                        w_res.kind = KIND_NOT_TX;
                    end
                    w_res.out_seq = n_local;
                    w_hdr = 1'b1;
                end
            end
            OP_TICK: begin
                if (w_idle_inc > r_limit) begin
                    n_link   = LINK_DOWN;
                    n_local  = '0;
                    n_ra     = WIN_ONES;
                    n_latest = '0;
                    n_rmask  = '0;
                    n_rl     = RL_W'(WIN_W);
                    n_idle   = '0;
                    w_res.kind = KIND_DISCONNECT;
                end else begin
                    n_idle = w_idle_inc;
                    n_rl   = RL_W'(WIN_W);
                    w_res.kind = KIND_IDLE;
                    if (w_elig != '0) begin
                        w_res.out_seq = seq_back(r_local, w_oldest);
                        w_res.kind = (r_link == LINK_DOWN) ? KIND_NOT_TX : KIND_RESEND;
                        w_hdr = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_hdr) begin
            w_res.out_ack      = n_latest;
            w_res.out_ack_mask = n_rmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= IDLE_LIMIT_RESET;
            r_link   <= LINK_DOWN;
            r_local  <= '0;
            r_ra     <= WIN_ONES;
            r_latest <= '0;
            r_rmask  <= '0;
            r_rl     <= RL_W'(WIN_W);
            r_idle   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_take) begin
                r_link   <= n_link;
                r_local  <= n_local;
                r_ra     <= n_ra;
                r_latest <= n_latest;
                r_rmask  <= n_rmask;
                r_rl     <= n_rl;
                r_idle   <= n_idle;
            end
        end
    end

    // result queue
    assign empty    = (r_cnt == 2'd0);
    assign w_pop    = pop && !empty;
    assign o_result = r_q[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (o_take && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!o_take && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (o_take) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[r_wptr] <= w_res;
        end
    end

endmodule

`default_nettype wire

/* verif/reliable_udp_ack_window_test.sv */
`timescale 1ns / 1ps

module reliable_udp_ack_window_test;
    import rua_pkg::*;

    localparam int               CYCLE_LIMIT = 1_000_000;
    localparam int               SEQ_HALF    = 1 << (SEQ_W - 1);
    localparam int               SEQ_SPAN    = 1 << SEQ_W;
    localparam int               SEQ_MAX     = SEQ_SPAN - 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        LINK_DOWN = 2'd0,
        LINK_SYNC = 2'd1,
        LINK_UP   = 2'd2
    } t_link;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             is_sync;
        t_seq             seq;
        t_seq             ack;
        t_win             mask;
    } t_hdr_word;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               push           = 1'b0;
    logic               full;
    logic [CMD_W-1:0]   i_cmd          = '0;
    logic               i_is_sync      = 1'b0;
    logic [SEQ_W-1:0]   i_pkt_seq      = '0;
    logic [SEQ_W-1:0]   i_pkt_ack      = '0;
    logic [WIN_W-1:0]   i_pkt_ack_mask = '0;
    logic               empty;
    logic               pop            = 1'b0;
    logic [3:0]         o_kind;
    logic [SEQ_W-1:0]   o_out_seq;
    logic [SEQ_W-1:0]   o_out_ack;
    logic [WIN_W-1:0]   o_out_ack_mask;
    logic [WIN_W-1:0]   o_newly_acked;
    logic [SEQ_W-1:0]   o_acked_base;
    logic               i_cfg_we       = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata    = '0;

    // mirror of the connection state
    t_link              m_link         = LINK_DOWN;
    t_seq               m_local_seq    = '0;
    t_win               m_acked        = '1;
    t_seq               m_recv_latest  = '0;
    t_win               m_recv_mask    = '0;
    int                 m_resend_limit = WIN_W;
    logic [IDLE_W-1:0]  m_idle         = '0;
    logic [LIMIT_W-1:0] m_idle_limit   = IDLE_LIMIT_RESET;

    t_result replies_due[$];
    t_result want;
    int      mismatches   = 0;
    int      checked      = 0;
    int      words_sent   = 0;
    int      limit_writes = 0;
    int      cycles       = 0;
    int      kinds_seen[16];
    int      hold_left    = 0;
    int      rx_stall     = 0;
    bit      tx_gaps_on   = 1'b1;
    bit      rx_gaps_on   = 1'b1;
    bit      ack_starve   = 1'b0;

    reliable_udp_ack_window u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_is_sync      (i_is_sync),
        .i_pkt_seq      (i_pkt_seq),
        .i_pkt_ack      (i_pkt_ack),
        .i_pkt_ack_mask (i_pkt_ack_mask),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_out_seq      (o_out_seq),
        .o_out_ack      (o_out_ack),
        .o_out_ack_mask (o_out_ack_mask),
        .o_newly_acked  (o_newly_acked),
        .o_acked_base   (o_acked_base),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // signed distance a - b; exactly half the space counts as ahead when a > b
    function automatic int seq_gap(t_seq a, t_seq b);
        int d;
        d = int'(a) - int'(b);
        if (d < -SEQ_HALF) begin
            d += SEQ_SPAN;
        end else if (d > SEQ_HALF) begin
            d -= SEQ_SPAN;
        end
        return d;
    endfunction

    // zero is never used as a sequence number
    function automatic t_seq seq_succ(t_seq s);
        return (s == '1) ? t_seq'(1) : t_seq'(s + 1'b1);
    endfunction

    function automatic t_seq seq_rewind(t_seq s, int bias);
        int r;
        r = (int'(s) > bias) ? int'(s) - bias : int'(s) + SEQ_MAX - bias;
        return t_seq'(r);
    endfunction

    function automatic void clear_link();
        m_link         = LINK_DOWN;
        m_local_seq    = '0;
        m_acked        = '1;
        m_recv_latest  = '0;
        m_recv_mask    = '0;
        m_resend_limit = WIN_W;
        m_idle         = '0;
    endfunction

    function automatic bit take_seq(bit sync_msg);
        m_local_seq = seq_succ(m_local_seq);
        m_acked     = m_acked << 1;
        if (m_link == LINK_DOWN || (m_link == LINK_SYNC && !sync_msg)) begin
            return 1'b0;
        end
        if (m_resend_limit > 0) begin
            m_resend_limit--;
        end
        return 1'b1;
    endfunction

    function automatic t_result advance_window(t_hdr_word w);
        t_result r;
        bit      with_hdr;
        bit      keep;
        bit      found;
        int      sh;
        int      d;
        t_win    bitv;
        t_win    fresh;
        r        = '0;
        with_hdr = 1'b0;
        found    = 1'b0;
        case (w.cmd)
            CMD_PKT: begin
                m_idle = '0;
                if (w.is_sync) begin
                    if (m_link == LINK_DOWN) begin
                        m_recv_latest  = w.seq;
                        m_recv_mask    = t_win'(1);
                        m_acked        = '1;
                        m_resend_limit = WIN_W;
                        m_link         = LINK_SYNC;
                        void'(take_seq(1'b1));
                        r.kind    = KIND_SYNC_REPLY;
                        r.out_seq = m_local_seq;
                        with_hdr  = 1'b1;
                    end
                end else begin
                    if (m_link == LINK_SYNC) begin
                        m_link = LINK_UP;
                    end
                    if (m_link == LINK_UP) begin
                        sh   = seq_gap(w.seq, m_recv_latest);
                        keep = 1'b1;
                        if (sh == 0) begin
                            keep = 1'b0;
                        end else if (sh < 0) begin
                            if (-sh >= WIN_W) begin
                                keep = 1'b0;
                            end else begin
                                bitv = t_win'(1) << (-sh);
                                if ((m_recv_mask & bitv) != '0) begin
                                    keep = 1'b0;
                                end else begin
                                    m_recv_mask |= bitv;
                                end
                            end
                        end else begin
                            m_recv_latest = w.seq;
                            m_recv_mask   = (sh >= WIN_W) ? t_win'(1)
                                                          : ((m_recv_mask << sh) | t_win'(1));
                        end
                        if (keep) begin
                            d = seq_gap(m_local_seq, w.ack);
                            if (d >= 0 && d < WIN_W) begin
                                fresh         = ((~m_acked) >> d) & w.mask;
                                m_acked      |= fresh << d;
                                r.newly_acked = fresh;
                            end
                            r.kind       = KIND_DELIVER;
                            r.acked_base = w.ack;
                            with_hdr     = 1'b1;
                        end
                    end
                end
            end
            CMD_SEND: begin
                if (!m_acked[WIN_W-1]) begin
                    r.kind = KIND_HELD;
                end else begin
                    r.kind    = take_seq(1'b0) ? KIND_SENT : KIND_NOT_TX;
                    r.out_seq = m_local_seq;
                    with_hdr  = 1'b1;
                end
            end
            CMD_TICK: begin
                if (m_idle != '1) begin
                    m_idle++;
                end
                if (m_idle > m_idle_limit) begin
                    clear_link();
                    r.kind = KIND_DISCONNECT;
                end else begin
                    r.kind = KIND_IDLE;
                    if (m_acked != '1) begin
                        // oldest unacknowledged slot within the resend limit
                        for (int i = 1; i <= WIN_W && i <= m_resend_limit && !found; i++) begin
                            if (!m_acked[WIN_W-i]) begin
                                found     = 1'b1;
                                r.out_seq = seq_rewind(m_local_seq, WIN_W - i);
                                r.kind    = (m_link == LINK_DOWN) ? KIND_NOT_TX : KIND_RESEND;
                                with_hdr  = 1'b1;
                            end
                        end
                    end
                    m_resend_limit = WIN_W;
                end
            end
            default: begin
                r.kind = KIND_IGNORED;
            end
        endcase
        if (with_hdr) begin
            r.out_ack      = m_recv_latest;
            r.out_ack_mask = m_recv_mask;
        end
        return r;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic t_hdr_word make_word(logic [CMD_W-1:0] cmd, logic is_sync,
                                            t_seq seq, t_seq ack, t_win mask);
        t_hdr_word w;
        w.cmd     = cmd;
        w.is_sync = is_sync;
        w.seq     = seq;
        w.ack     = ack;
        w.mask    = mask;
        return w;
    endfunction

    function automatic t_win pick_mask();
        if (ack_starve) begin
            return $urandom & $urandom & $urandom;
        end
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed traffic around the current window, some noise
    function automatic t_hdr_word random_word();
        t_hdr_word w;
        int        roll;
        int        off;
        w.cmd     = CMD_TICK;
        w.is_sync = 1'b0;
        w.seq     = t_seq'($urandom);
        w.ack     = t_seq'($urandom);
        w.mask    = pick_mask();
        roll      = $urandom_range(0, 99);
        if (roll < 4) begin
            w.cmd     = CMD_W'($urandom_range(0, 3));
            w.is_sync = 1'($urandom_range(0, 1));
        end else if (m_link == LINK_DOWN) begin
            if (roll < 70) begin
                w.cmd     = CMD_PKT;
                w.is_sync = 1'b1;
            end else begin
                w.cmd = (roll < 85) ? CMD_SEND : CMD_TICK;
            end
        end else if (m_link == LINK_SYNC && roll < 60) begin
            w.cmd = CMD_PKT;
            w.seq = t_seq'(m_recv_latest + $urandom_range(1, 3));
        end else if (roll < 48) begin
            w.cmd     = CMD_PKT;
            w.is_sync = (roll < 7);
            case ($urandom_range(0, 9))
                8:       w.seq = t_seq'(m_recv_latest + $urandom_range(32, 2000));
                9:       w.seq = t_seq'($urandom);
                default: begin
                    off   = int'($urandom_range(0, 75)) - 35;
                    w.seq = t_seq'(int'(m_recv_latest) + off);
                end
            endcase
            case ($urandom_range(0, 9))
                7:       w.ack = t_seq'(m_local_seq + $urandom_range(1, 4));
                8, 9:    w.ack = t_seq'($urandom);
                default: w.ack = t_seq'(m_local_seq - $urandom_range(0, 33));
            endcase
        end else if (roll < 85) begin
            w.cmd = CMD_SEND;
        end
        return w;
    endfunction

    task automatic send_word(input t_hdr_word w);
        int gap;
        push           <= 1'b1;
        i_cmd          <= w.cmd;
        i_is_sync      <= w.is_sync;
        i_pkt_seq      <= w.seq;
        i_pkt_ack      <= w.ack;
        i_pkt_ack_mask <= w.mask;
        do @(posedge i_clk); while (full !== 1'b0);
        replies_due.push_back(advance_window(w));
        words_sent++;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = idle_len();
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the input side until every expected word is out
    task automatic drain();
        push <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        m_idle_limit  = value;
        limit_writes++;
    endtask

    task automatic link_setup_test();
        send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
        send_word(make_word(CMD_PKT, 1'b0, '0, '0, '0));
        send_word(make_word(CMD_SEND, 1'b0, '1, '1, '1));
        send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
        send_word(make_word(CMD_UNUSED, 1'b1, '1, '1, '1));
        send_word(make_word(CMD_PKT, 1'b1, 16'hfff0, '1, '1));
        send_word(make_word(CMD_PKT, 1'b1, 16'h1234, '0, '0));
        send_word(make_word(CMD_SEND, 1'b0, '0, '0, '0));
        send_word(make_word(CMD_PKT, 1'b0, 16'hfff8, m_local_seq, '1));
    endtask

    task automatic receive_window_test();
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest, m_local_seq, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest - 16'd4, m_local_seq, '0));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest - 16'd4, m_local_seq, '0));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest - 16'd40, m_local_seq, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest - 16'd32, m_local_seq, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest - 16'd31, m_local_seq, '1));
        // runs past the top of the sequence space
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'd100, m_local_seq, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'h8000, m_local_seq, '1));
    endtask

    task automatic ack_and_resend_test();
        repeat (3) send_word(make_word(CMD_SEND, 1'b0, '0, '0, '0));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'd1, m_local_seq + 16'd5, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'd1, m_local_seq - 16'd32, '1));
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'd1, m_local_seq - 16'd1,
                            32'h5555_5555));
        send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
    endtask

    task automatic idle_limit_test();
        drain();
        write_limit(16'd1);
        send_word(make_word(CMD_PKT, 1'b0, m_recv_latest + 16'd1, m_local_seq, '0));
        repeat (2) send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
    endtask

    // a run of ticks under the largest limit, then a small limit drops the link
    task automatic idle_saturation_test();
        drain();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        write_limit('1);
        repeat (40) send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
        drain();
        write_limit(16'd3);
        send_word(make_word(CMD_TICK, 1'b0, '0, '0, '0));
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic backpressure_test();
        drain();
        tx_gaps_on = 1'b0;
        hold_left  = 250;
        repeat (24) send_word(random_word());
        tx_gaps_on = 1'b1;
        drain();
    endtask

    task automatic random_traffic_test(input int count, input logic [LIMIT_W-1:0] limit);
        drain();
        write_limit(limit);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
                ack_starve = ($urandom_range(0, 3) == 0);
            end
            send_word(random_word());
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s of result %0d: expected %h, got %h",
                     field, checked, exp_val, got_val);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (rx_stall > 0) begin
                pop <= 1'b0;
                rx_stall--;
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                rx_stall = idle_len() - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word with nothing expected: kind %0d", o_kind);
                end
            end else begin
                want = replies_due.pop_front();
                if (o_kind !== want.kind) begin
                    flag_mismatch("kind", 32'(want.kind), 32'(o_kind));
                end
                if (o_out_seq !== want.out_seq) begin
                    flag_mismatch("out_seq", 32'(want.out_seq), 32'(o_out_seq));
                end
                if (o_out_ack !== want.out_ack) begin
                    flag_mismatch("out_ack", 32'(want.out_ack), 32'(o_out_ack));
                end
                if (o_out_ack_mask !== want.out_ack_mask) begin
                    flag_mismatch("out_ack_mask", want.out_ack_mask, o_out_ack_mask);
                end
                if (o_newly_acked !== want.newly_acked) begin
                    flag_mismatch("newly_acked", want.newly_acked, o_newly_acked);
                end
                if (o_acked_base !== want.acked_base) begin
                    flag_mismatch("acked_base", 32'(want.acked_base), 32'(o_acked_base));
                end
                kinds_seen[int'(want.kind)]++;
                checked++;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        foreach (kinds_seen[k]) kinds_seen[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        link_setup_test();
        receive_window_test();
        ack_and_resend_test();
        idle_limit_test();
        backpressure_test();
        random_traffic_test(230, IDLE_LIMIT_RESET);
        random_traffic_test(230, 16'($urandom_range(4, 40)));
        random_traffic_test(230, 16'd1);
        random_traffic_test(230, '1);
        random_traffic_test(230, 16'($urandom_range(1, SEQ_MAX)));
        idle_saturation_test();
        drain();

        $display("covered %0d words over %0d idle-limit settings, %0d results checked",
                 words_sent, limit_writes, checked);
        $display("deliver %0d, sync reply %0d, sent %0d, held %0d, resend %0d, disconnect %0d",
                 kinds_seen[KIND_DELIVER], kinds_seen[KIND_SYNC_REPLY], kinds_seen[KIND_SENT],
                 kinds_seen[KIND_HELD], kinds_seen[KIND_RESEND], kinds_seen[KIND_DISCONNECT]);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
